// ===== rtl/hvn_pkg.sv =====
// ============================================================================
// hvn_pkg
// Shared types and constants of the heightmap vertex normal engine.
// ============================================================================
`default_nettype none

package hvn_pkg;

   typedef logic [1:0] op_type;
   localparam op_type OP_LOAD  = 2'd0;
   localparam op_type OP_QUERY = 2'd1;
   localparam op_type OP_OOG   = 2'd2;

   localparam logic [1:0] CSR_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_STRETCH = 2'd2;

   typedef struct packed {
      op_type     op;
      logic [7:0] column;
      logic [7:0] row;
      logic [7:0] height;
   } entry_type;

   typedef struct packed {
      logic [7:0] width;
      logic [7:0] length;
      logic [7:0] stretch;
   } cfg_type;

   localparam int QUO_W = 24;

endpackage

`default_nettype wire

// ===== rtl/hvn_front.sv =====
// ============================================================================
// hvn_front
// Control registers with clamping, request classification and queue push.
// ============================================================================
`default_nettype none

module hvn_front #(
   parameter int MAX_CELLS = 255
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              queue_full,
   input  wire logic              req_kind,
   input  wire logic [7:0]        req_column,
   input  wire logic [7:0]        req_row,
   input  wire logic [7:0]        req_height,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data,
   output logic                   push,
   output hvn_pkg::entry_type     push_entry,
   output hvn_pkg::cfg_type       cfg
);
   import hvn_pkg::*;

   logic [7:0] width_ff, length_ff, stretch_ff;
   logic [7:0] w, l, s;
   logic       keep;
   op_type     op;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 8'd255;
         length_ff  <= 8'd255;
         stretch_ff <= 8'd5;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH:   width_ff   <= csr_data;
            CSR_LENGTH:  length_ff  <= csr_data;
            CSR_STRETCH: stretch_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      w = width_ff;
      if (w == 8'd0) w = 8'd1;
      else if (32'(w) > MAX_CELLS) w = 8'(MAX_CELLS);
      l = length_ff;
      if (l < 8'd2) l = 8'd2;
      else if (32'(l) > MAX_CELLS) l = 8'(MAX_CELLS);
      s = stretch_ff;
      if (s == 8'd0) s = 8'd1;
   end

   always_comb begin
      keep = 1'b1;
      if (!req_kind) begin
         op   = OP_LOAD;
         keep = (32'(req_column) <= MAX_CELLS) && (32'(req_row) <= MAX_CELLS);
      end else if (req_column > w || req_row > l) begin
         op = OP_OOG;
      end else begin
         op = OP_QUERY;
      end
   end

   assign cfg        = '{width: w, length: l, stretch: s};
   assign push       = start && !queue_full && keep;
   assign push_entry = '{op: op, column: req_column, row: req_row, height: req_height};

endmodule

`default_nettype wire

// ===== rtl/hvn_queue.sv =====
// ============================================================================
// hvn_queue
// Two-entry request queue between front and back.
// ============================================================================
`default_nettype none

module hvn_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hvn_pkg::entry_type push_entry,
   input  wire logic              pop,
   output logic                   head_valid,
   output hvn_pkg::entry_type     head,
   output logic                   full
);
   import hvn_pkg::*;

   localparam int DEPTH = 2;

   entry_type  slots_ff [DEPTH];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_entry;
   end

   assign head       = slots_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'(DEPTH));

endmodule

`default_nettype wire

// ===== rtl/hvn_back.sv =====
// ============================================================================
// hvn_back
// Height store and query sequencer: neighbor reads, face normals, root and
// divide steps, result registers.
// ============================================================================
`default_nettype none

module hvn_back #(
   parameter int MAX_CELLS = 255
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire hvn_pkg::entry_type head,
   input  wire hvn_pkg::cfg_type   cfg,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic signed [23:0]      rsp_pos_x,
   output logic [22:0]             rsp_pos_y,
   output logic signed [23:0]      rsp_pos_z,
   output logic signed [15:0]      rsp_norm_x,
   output logic signed [15:0]      rsp_norm_y,
   output logic signed [15:0]      rsp_norm_z,
   output logic [16:0]             rsp_tex_u,
   output logic [16:0]             rsp_tex_v,
   output logic                    rsp_out_of_grid
);
   import hvn_pkg::*;

   localparam int STRIDE = MAX_CELLS + 1;
   localparam int DEPTH  = STRIDE * STRIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_TRI  = 3'd2;
   localparam logic [2:0] ST_SQ   = 3'd3;
   localparam logic [2:0] ST_ROOT = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   localparam logic [2:0] K_Y   = 3'd0;
   localparam logic [2:0] K_U   = 3'd1;
   localparam logic [2:0] K_V   = 3'd2;
   localparam logic [2:0] K_TRI = 3'd3;
   localparam logic [2:0] K_FIN = 3'd4;

   localparam logic [2:0] TRI_END  = 3'd7;
   localparam logic [4:0] DIV_LAST = 5'(QUO_W + 1);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic       we;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  col_ff, col_in, row_ff, row_in;
   logic [1:0]  rd_r_ff, rd_r_in, rd_c_ff, rd_c_in;
   logic [1:0]  cap_r_ff, cap_r_in, cap_c_ff, cap_c_in;
   logic        cap_en_ff, cap_en_in;
   logic [7:0]  hn_ff [3][3];
   logic [2:0]  t_ff, t_in;
   logic [1:0]  j_ff, j_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   logic signed [24:0] vec0_ff, vec0_in, vec1_ff, vec1_in, vec2_ff, vec2_in;
   logic signed [24:0] acc0_ff, acc0_in, acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic [47:0] s_ff, s_in;
   logic [63:0] v_ff, v_in, r_ff, r_in, b_ff, b_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QUO_W-1:0] low_ff, low_in;

   logic        strobe_ff, strobe_in, oog_ff, oog_in;
   logic signed [23:0] posx_ff, posx_in, posz_ff, posz_in;
   logic [22:0] posy_ff, posy_in;
   logic [16:0] texu_ff, texu_in, texv_ff, texv_in;
   logic signed [15:0] nrm0_ff, nrm0_in, nrm1_ff, nrm1_in, nrm2_ff, nrm2_in;

   logic [7:0]  tl, tr, ll, lr;
   logic signed [8:0]  da, db, l9;
   logic signed [17:0] nx, nz;
   logic [15:0] dstep;
   logic        cell_ok, tri_ok;
   logic signed [9:0]  dxw, dzw;
   logic signed [8:0]  s9;
   logic signed [18:0] px, pz;
   logic [8:0]  rrow, rcol;
   logic signed [49:0] sq_full;
   logic [63:0] rad, rb, r_step, v_step;
   logic [23:0] mag;
   logic [63:0] dvd;
   logic [31:0] dvs;
   logic [32:0] trial;
   logic        ge;
   logic signed [24:0] sq;
   logic [14:0] sat;
   logic signed [15:0] nsat;
   logic [31:0] root_nx;

   // datapath helpers
   always_comb begin
      unique case ({t_ff[2], t_ff[1]})
         2'd0: begin
            tl = hn_ff[0][0]; tr = hn_ff[0][1]; ll = hn_ff[1][0]; lr = hn_ff[1][1];
         end
         2'd1: begin
            tl = hn_ff[0][1]; tr = hn_ff[0][2]; ll = hn_ff[1][1]; lr = hn_ff[1][2];
         end
         2'd2: begin
            tl = hn_ff[1][0]; tr = hn_ff[1][1]; ll = hn_ff[2][0]; lr = hn_ff[2][1];
         end
         default: begin
            tl = hn_ff[1][1]; tr = hn_ff[1][2]; ll = hn_ff[2][1]; lr = hn_ff[2][2];
         end
      endcase
      da = t_ff[0] ? ($signed({1'b0, lr}) - $signed({1'b0, ll}))
                   : ($signed({1'b0, tr}) - $signed({1'b0, tl}));
      db = t_ff[0] ? ($signed({1'b0, lr}) - $signed({1'b0, tr}))
                   : ($signed({1'b0, ll}) - $signed({1'b0, tl}));
      l9 = $signed({1'b0, cfg.length});
      nx = -(da * l9);
      nz = db * l9;
      dstep = cfg.stretch * (cfg.length - 8'd1);
      cell_ok = (t_ff[1] ? (col_ff < cfg.width) : (col_ff != 8'd0)) &&
                (t_ff[2] ? (row_ff < cfg.length) : (row_ff != 8'd0));
      tri_ok = cell_ok && !(!t_ff[0] && t_ff[2:1] == 2'd0) &&
               !(t_ff[0] && t_ff[2:1] == 2'd3);

      dxw = $signed({1'b0, head.column, 1'b0}) - $signed({2'b0, cfg.width});
      dzw = $signed({2'b0, cfg.length}) - $signed({1'b0, head.row, 1'b0});
      s9  = $signed({1'b0, cfg.stretch});
      px  = dxw * s9;
      pz  = dzw * s9;

      rrow = {1'b0, row_ff} + {7'b0, rd_r_ff} - 9'd1;
      rcol = {1'b0, col_ff} + {7'b0, rd_c_ff} - 9'd1;
      rd_addr = ADDR_W'(int'(rrow) * STRIDE + int'(rcol));
      wr_addr = ADDR_W'(int'(head.row) * STRIDE + int'(head.column));

      sq_full = vec0_ff * vec0_ff;

      rad = fin_ff ? {s_ff, 16'b0} : {s_ff[35:0], 28'b0};
      rb  = r_ff + b_ff;
      if (v_ff >= rb) begin
         v_step = v_ff - rb;
         r_step = (r_ff >> 1) + b_ff;
      end else begin
         v_step = v_ff;
         r_step = r_ff >> 1;
      end
      root_nx = r_step[31:0];
      if (fin_ff && root_nx == 32'd0) root_nx = 32'd1;

      mag = vec0_ff[24] ? 24'(-vec0_ff) : vec0_ff[23:0];
      unique case (kind_ff)
         K_Y: begin
            dvd = 64'({16'(hn_ff[1][1]) * 16'(cfg.length), 9'b0}) +
                  64'(cfg.length - 8'd1);
            dvs = 32'({cfg.length - 8'd1, 1'b0});
         end
         K_U: begin
            dvd = 64'({col_ff, 17'b0}) + 64'(cfg.width);
            dvs = 32'({cfg.width, 1'b0});
         end
         K_V: begin
            dvd = 64'({row_ff, 17'b0}) + 64'(cfg.length);
            dvs = 32'({cfg.length, 1'b0});
         end
         K_TRI: begin
            dvd = 64'({mag, 34'b0}) + 64'(root_ff >> 1);
            dvs = root_ff;
         end
         default: begin
            dvd = 64'({mag, 22'b0}) + 64'(root_ff >> 1);
            dvs = root_ff;
         end
      endcase

      trial = {rem_ff, low_ff[QUO_W-1]};
      ge    = trial >= {1'b0, dvs_ff};
      sq    = vec0_ff[24] ? -$signed({1'b0, low_ff}) : $signed({1'b0, low_ff});
      sat   = (low_ff > 24'd16384) ? 15'd16384 : low_ff[14:0];
      nsat  = vec0_ff[24] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
   end

   // sequencer
   always_comb begin
      state_in = state_ff; kind_in = kind_ff; col_in = col_ff; row_in = row_ff;
      rd_r_in = rd_r_ff; rd_c_in = rd_c_ff;
      cap_en_in = 1'b0; cap_r_in = rd_r_ff; cap_c_in = rd_c_ff;
      t_in = t_ff; j_in = j_ff; cnt_in = cnt_ff; fin_in = fin_ff;
      vec0_in = vec0_ff; vec1_in = vec1_ff; vec2_in = vec2_ff;
      acc0_in = acc0_ff; acc1_in = acc1_ff; acc2_in = acc2_ff;
      s_in = s_ff; v_in = v_ff; r_in = r_ff; b_in = b_ff; root_in = root_ff;
      rem_in = rem_ff; dvs_in = dvs_ff; low_in = low_ff;
      strobe_in = 1'b0; oog_in = oog_ff;
      posx_in = posx_ff; posy_in = posy_ff; posz_in = posz_ff;
      texu_in = texu_ff; texv_in = texv_ff;
      nrm0_in = nrm0_ff; nrm1_in = nrm1_ff; nrm2_in = nrm2_ff;
      pop = 1'b0; we = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               unique case (head.op)
                  OP_LOAD: we = 1'b1;
                  OP_OOG: begin
                     strobe_in = 1'b1; oog_in = 1'b1;
                     posx_in = '0; posy_in = '0; posz_in = '0;
                     texu_in = '0; texv_in = '0;
                     nrm0_in = '0; nrm1_in = '0; nrm2_in = '0;
                  end
                  OP_QUERY: begin
                     oog_in  = 1'b0;
                     col_in  = head.column;
                     row_in  = head.row;
                     posx_in = 24'({px, 7'b0});
                     posz_in = 24'({pz, 7'b0});
                     rd_r_in = 2'd0; rd_c_in = 2'd0;
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            cap_en_in = 1'b1;
            if (rd_c_ff == 2'd2) begin
               rd_c_in = 2'd0;
               if (rd_r_ff == 2'd2) begin
                  state_in = ST_DIV; kind_in = K_Y; cnt_in = 5'd0;
               end else begin
                  rd_r_in = rd_r_ff + 2'd1;
               end
            end else begin
               rd_c_in = rd_c_ff + 2'd1;
            end
         end
         ST_TRI: begin
            s_in = '0; j_in = 2'd0;
            if (t_ff == TRI_END) begin
               vec0_in = acc0_ff; vec1_in = acc1_ff; vec2_in = acc2_ff;
               fin_in = 1'b1; state_in = ST_SQ;
            end else if (tri_ok) begin
               vec0_in = {{7{nx[17]}}, nx};
               vec1_in = $signed({9'b0, dstep});
               vec2_in = {{7{nz[17]}}, nz};
               fin_in = 1'b0; state_in = ST_SQ;
            end else begin
               t_in = t_ff + 3'd1;
            end
         end
         ST_SQ: begin
            s_in = s_ff + sq_full[47:0];
            vec0_in = vec1_ff; vec1_in = vec2_ff; vec2_in = vec0_ff;
            if (j_ff == 2'd2) begin
               j_in = 2'd0; cnt_in = 5'd0; state_in = ST_ROOT;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         ST_ROOT: begin
            if (cnt_ff == 5'd0) begin
               v_in = rad; r_in = '0; b_in = 64'd1 << 62; cnt_in = 5'd1;
            end else begin
               v_in = v_step; r_in = r_step; b_in = b_ff >> 2;
               if (b_ff == 64'd1) begin
                  root_in = root_nx;
                  kind_in = fin_ff ? K_FIN : K_TRI;
                  cnt_in = 5'd0; state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff == 5'd0) begin
               rem_in = dvd[55:24];
               low_in = dvd[QUO_W-1:0];
               dvs_in = dvs;
               cnt_in = 5'd1;
            end else if (cnt_ff != DIV_LAST) begin
               rem_in = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
               low_in = {low_ff[QUO_W-2:0], ge};
               cnt_in = cnt_ff + 5'd1;
            end else begin
               cnt_in = 5'd0;
               unique case (kind_ff)
                  K_Y: begin posy_in = low_ff[22:0]; kind_in = K_U; end
                  K_U: begin texu_in = low_ff[16:0]; kind_in = K_V; end
                  K_V: begin
                     texv_in = low_ff[16:0];
                     acc0_in = '0; acc1_in = '0; acc2_in = '0;
                     t_in = 3'd0; state_in = ST_TRI;
                  end
                  K_TRI: begin
                     acc0_in = acc1_ff; acc1_in = acc2_ff; acc2_in = acc0_ff + sq;
                     vec0_in = vec1_ff; vec1_in = vec2_ff; vec2_in = vec0_ff;
                     if (j_ff == 2'd2) begin
                        j_in = 2'd0; t_in = t_ff + 3'd1; state_in = ST_TRI;
                     end else begin
                        j_in = j_ff + 2'd1;
                     end
                  end
                  default: begin
                     nrm0_in = nrm1_ff; nrm1_in = nrm2_ff; nrm2_in = nsat;
                     vec0_in = vec1_ff; vec1_in = vec2_ff; vec2_in = vec0_ff;
                     if (j_ff == 2'd2) begin
                        j_in = 2'd0; state_in = ST_DONE;
                     end else begin
                        j_in = j_ff + 2'd1;
                     end
                  end
               endcase
            end
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         cap_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         cap_en_ff <= cap_en_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; col_ff <= col_in; row_ff <= row_in;
      rd_r_ff <= rd_r_in; rd_c_ff <= rd_c_in; cap_r_ff <= cap_r_in; cap_c_ff <= cap_c_in;
      t_ff <= t_in; j_ff <= j_in; cnt_ff <= cnt_in; fin_ff <= fin_in;
      vec0_ff <= vec0_in; vec1_ff <= vec1_in; vec2_ff <= vec2_in;
      acc0_ff <= acc0_in; acc1_ff <= acc1_in; acc2_ff <= acc2_in;
      s_ff <= s_in; v_ff <= v_in; r_ff <= r_in; b_ff <= b_in; root_ff <= root_in;
      rem_ff <= rem_in; dvs_ff <= dvs_in; low_ff <= low_in;
      oog_ff <= oog_in; posx_ff <= posx_in; posy_ff <= posy_in; posz_ff <= posz_in;
      texu_ff <= texu_in; texv_ff <= texv_in;
      nrm0_ff <= nrm0_in; nrm1_ff <= nrm1_in; nrm2_ff <= nrm2_in;
   end

   always_ff @(posedge clock) begin
      if (cap_en_ff) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               if (cap_r_ff == 2'(i) && cap_c_ff == 2'(k)) hn_ff[i][k] <= rd_data_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= head.height;
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid       = strobe_ff;
   assign rsp_out_of_grid = oog_ff;
   assign rsp_pos_x       = posx_ff;
   assign rsp_pos_y       = posy_ff;
   assign rsp_pos_z       = posz_ff;
   assign rsp_tex_u       = texu_ff;
   assign rsp_tex_v       = texv_ff;
   assign rsp_norm_x      = nrm0_ff;
   assign rsp_norm_y      = nrm1_ff;
   assign rsp_norm_z      = nrm2_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> state_ff == ST_IDLE)
      else $error("result strobe outside idle");

   a_oog_zero: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && oog_ff) |-> (posx_ff == 0 && posy_ff == 0 && posz_ff == 0 &&
                                 nrm0_ff == 0 && nrm1_ff == 0 && nrm2_ff == 0))
      else $error("out-of-grid result not zero");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !oog_ff) |-> (nrm0_ff <= 16384 && nrm0_ff >= -16384 &&
                                  nrm1_ff <= 16384 && nrm1_ff >= -16384 &&
                                  nrm2_ff <= 16384 && nrm2_ff >= -16384))
      else $error("normal component out of range");

   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= DIV_LAST))
      else $error("divider step count overrun");

endmodule

`default_nettype wire

// ===== rtl/heightmap_vertex_normal_engine.sv =====
// ============================================================================
// heightmap_vertex_normal_engine
// Terrain height store with per-vertex position, texture and smooth normal.
// ============================================================================
// Requests enter when start is high and busy is low. req_kind 0 stores
// req_height at (req_row, req_column); req_kind 1 queries that vertex.
// Loads give no result; a query gives one result, strobed by rsp_valid for
// exactly one cycle. The receiver cannot stall: results must be taken then.
// csr_write with csr_index writes cells_width, cells_length or
// stretch_factor; write only while the block is idle.
// A two-entry queue parts the front from the back; busy is high while it
// is full. The back takes one request at a time: loads and out-of-grid
// queries are handled from idle; an in-grid query reads the neighbors,
// then runs the shared 24-step divider and 32-step square root of the
// back sequencer for the height, texture, each adjacent triangle and
// the final normalize.
// Reset restores the register defaults and empties the queue; the height
// store is not cleared and must be loaded before it is queried.
// ============================================================================
`default_nettype none

module heightmap_vertex_normal_engine #(
   parameter int MAX_CELLS = 255
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_kind,
   input  wire logic [7:0]         req_column,
   input  wire logic [7:0]         req_row,
   input  wire logic [7:0]         req_height,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_data,
   output logic                    rsp_valid,
   output logic signed [23:0]      rsp_pos_x,
   output logic [22:0]             rsp_pos_y,
   output logic signed [23:0]      rsp_pos_z,
   output logic signed [15:0]      rsp_norm_x,
   output logic signed [15:0]      rsp_norm_y,
   output logic signed [15:0]      rsp_norm_z,
   output logic [16:0]             rsp_tex_u,
   output logic [16:0]             rsp_tex_v,
   output logic                    rsp_out_of_grid
);
   import hvn_pkg::*;

   logic      push, pop, head_valid, full;
   entry_type push_entry, head;
   cfg_type   cfg;

   hvn_front #(.MAX_CELLS(MAX_CELLS)) u_front (
      .clock(clock), .reset(reset), .start(start), .queue_full(full),
      .req_kind(req_kind), .req_column(req_column), .req_row(req_row),
      .req_height(req_height), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .push(push), .push_entry(push_entry), .cfg(cfg)
   );

   hvn_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry),
      .pop(pop), .head_valid(head_valid), .head(head), .full(full)
   );

   hvn_back #(.MAX_CELLS(MAX_CELLS)) u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head(head),
      .cfg(cfg), .pop(pop), .rsp_valid(rsp_valid), .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z), .rsp_norm_x(rsp_norm_x),
      .rsp_norm_y(rsp_norm_y), .rsp_norm_z(rsp_norm_z), .rsp_tex_u(rsp_tex_u),
      .rsp_tex_v(rsp_tex_v), .rsp_out_of_grid(rsp_out_of_grid)
   );

   assign busy = full;

endmodule

`default_nettype wire
